// ----- src/lr_pkg.sv -----
// Package for the line rasterizer: default widths and the item mode codes.
// Used by lr_step and line_rasterizer_top; depends on nothing else.
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS_DEF = 4;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_STEP  = 1'b1
    } mode_t;

endpackage

`default_nettype wire

// ----- src/lr_step.sv -----
// Combinational step of the Bresenham walker: loads a line or advances one pixel.
// Depends on lr_pkg for the mode codes.
`default_nettype none

module lr_step
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COLOR_BITS = COLOR_BITS_DEF,
    localparam int ErrW      = COORD_BITS + 2
) (
    input  wire logic                   item_mode,
    input  wire logic [COORD_BITS-1:0]  start_x,
    input  wire logic [COORD_BITS-1:0]  start_y,
    input  wire logic [COORD_BITS-1:0]  end_x_in,
    input  wire logic [COORD_BITS-1:0]  end_y_in,
    input  wire logic [COLOR_BITS-1:0]  color,
    input  wire logic                   active,
    input  wire logic [COORD_BITS-1:0]  cur_x,
    input  wire logic [COORD_BITS-1:0]  cur_y,
    input  wire logic [COORD_BITS-1:0]  target_x,
    input  wire logic [COORD_BITS-1:0]  target_y,
    input  wire logic [COORD_BITS-1:0]  delta_x,
    input  wire logic [COORD_BITS-1:0]  delta_y,
    input  wire logic                   dir_x_neg,
    input  wire logic                   dir_y_neg,
    input  wire logic [ErrW-1:0]        error_term,
    input  wire logic [COLOR_BITS-1:0]  line_color,
    output logic                        active_next,
    output logic [COORD_BITS-1:0]       cur_x_next,
    output logic [COORD_BITS-1:0]       cur_y_next,
    output logic [COORD_BITS-1:0]       target_x_next,
    output logic [COORD_BITS-1:0]       target_y_next,
    output logic [COORD_BITS-1:0]       delta_x_next,
    output logic [COORD_BITS-1:0]       delta_y_next,
    output logic                        dir_x_neg_next,
    output logic                        dir_y_neg_next,
    output logic [ErrW-1:0]             error_term_next,
    output logic [COLOR_BITS-1:0]       line_color_next,
    output logic                        produce,
    output logic                        fin
);

    logic                   hswap;
    logic                   vswap;
    logic [COORD_BITS-1:0]  sx0;
    logic [COORD_BITS-1:0]  sx1;
    logic [COORD_BITS-1:0]  sy0;
    logic [COORD_BITS-1:0]  sy1;
    logic                   ld_xneg;
    logic                   ld_yneg;
    logic [COORD_BITS-1:0]  ld_dx;
    logic [COORD_BITS-1:0]  ld_dy;
    logic signed [ErrW:0]   e2;
    logic signed [ErrW:0]   dx_ext;
    logic signed [ErrW:0]   dy_ext;
    logic                   step_x;
    logic                   step_y;

    // Axis-aligned lines are swept from the smaller endpoint upward.
    assign hswap = (start_y == end_y_in) && (end_x_in < start_x);
    assign vswap = !hswap && (start_x == end_x_in) && (end_y_in < start_y);
    assign sx0   = hswap ? end_x_in : start_x;
    assign sx1   = hswap ? start_x  : end_x_in;
    assign sy0   = vswap ? end_y_in : start_y;
    assign sy1   = vswap ? start_y  : end_y_in;

    assign ld_xneg = sx1 < sx0;
    assign ld_yneg = sy1 < sy0;
    assign ld_dx   = ld_xneg ? sx0 - sx1 : sx1 - sx0;
    assign ld_dy   = ld_yneg ? sy0 - sy1 : sy1 - sy0;

    assign fin     = (cur_x == target_x) && (cur_y == target_y);
    assign produce = (item_mode == MODE_STEP) && active;

    assign e2     = {error_term, 1'b0};
    assign dx_ext = $signed({3'b000, delta_x});
    assign dy_ext = $signed({3'b000, delta_y});
    assign step_x = e2 > -dy_ext;
    assign step_y = e2 < dx_ext;

    always_comb
    begin
        active_next     = active;
        cur_x_next      = cur_x;
        cur_y_next      = cur_y;
        target_x_next   = target_x;
        target_y_next   = target_y;
        delta_x_next    = delta_x;
        delta_y_next    = delta_y;
        dir_x_neg_next  = dir_x_neg;
        dir_y_neg_next  = dir_y_neg;
        error_term_next = error_term;
        line_color_next = line_color;
        if (item_mode == MODE_START)
        begin
            active_next     = 1'b1;
            cur_x_next      = sx0;
            cur_y_next      = sy0;
            target_x_next   = sx1;
            target_y_next   = sy1;
            delta_x_next    = ld_dx;
            delta_y_next    = ld_dy;
            dir_x_neg_next  = ld_xneg;
            dir_y_neg_next  = ld_yneg;
            error_term_next = {2'b00, ld_dx} - {2'b00, ld_dy};
            line_color_next = color;
        end
        else if (active)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                // Both axis decisions use the error value from before this step.
                error_term_next = error_term
                                  - (step_x ? {2'b00, delta_y} : {ErrW{1'b0}})
                                  + (step_y ? {2'b00, delta_x} : {ErrW{1'b0}});
                if (step_x)
                begin
                    cur_x_next = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (step_y)
                begin
                    cur_y_next = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/line_rasterizer_top.sv -----
// Top level of the Bresenham line rasterizer: input register, line state, result register.
// Depends on lr_pkg and lr_step.
//
//  channel | direction | signals                      | content
//  s_axis  | in        | s_tvalid s_tready s_tdata    | start item or step request
//          |           | s_tuser                      | mode
//  m_axis  | out       | m_tvalid m_tready m_tdata    | one pixel
//          |           | m_tlast                      | final pixel of the line
//
// Each beat waits in the input register and, if it yields a pixel, is registered into
// the result register as it advances; one beat per clock is sustained while the result is not stalled.
// Per axis, one compare, one error add and one coordinate add lie between registers.
// Reset clears all valid flags and leaves no line active.
// A stalled result only holds back a beat that would produce another pixel.
`default_nettype none

module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int COLOR_BITS  = COLOR_BITS_DEF,
    localparam int SDataW     = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
    localparam int MDataW     = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
    localparam int ErrW       = COORD_BITS + 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, end_x_in, end_y_in, color, zero fill
    input  wire logic [SDataW-1:0]  s_tdata,
    // mode
    input  wire logic               s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [MDataW-1:0]       m_tdata,
    // last
    output logic                    m_tlast
);

    logic                   in_valid_reg;
    logic                   in_mode_reg;
    logic [COORD_BITS-1:0]  in_sx_reg;
    logic [COORD_BITS-1:0]  in_sy_reg;
    logic [COORD_BITS-1:0]  in_ex_reg;
    logic [COORD_BITS-1:0]  in_ey_reg;
    logic [COLOR_BITS-1:0]  in_color_reg;

    logic                   active_reg;
    logic [COORD_BITS-1:0]  cur_x_reg;
    logic [COORD_BITS-1:0]  cur_y_reg;
    logic [COORD_BITS-1:0]  target_x_reg;
    logic [COORD_BITS-1:0]  target_y_reg;
    logic [COORD_BITS-1:0]  delta_x_reg;
    logic [COORD_BITS-1:0]  delta_y_reg;
    logic                   dir_x_neg_reg;
    logic                   dir_y_neg_reg;
    logic [ErrW-1:0]        error_term_reg;
    logic [COLOR_BITS-1:0]  line_color_reg;

    logic                   active_next;
    logic [COORD_BITS-1:0]  cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_next;
    logic [COORD_BITS-1:0]  target_x_next;
    logic [COORD_BITS-1:0]  target_y_next;
    logic [COORD_BITS-1:0]  delta_x_next;
    logic [COORD_BITS-1:0]  delta_y_next;
    logic                   dir_x_neg_next;
    logic                   dir_y_neg_next;
    logic [ErrW-1:0]        error_term_next;
    logic [COLOR_BITS-1:0]  line_color_next;

    logic                   out_valid_reg;
    logic [COORD_BITS-1:0]  out_x_reg;
    logic [COORD_BITS-1:0]  out_y_reg;
    logic [COLOR_BITS-1:0]  out_color_reg;
    logic                   out_last_reg;

    logic                   produce;
    logic                   fin;
    logic                   advance;
    logic                   s_take;

    lr_step #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_step (
        .item_mode       (in_mode_reg),
        .start_x         (in_sx_reg),
        .start_y         (in_sy_reg),
        .end_x_in        (in_ex_reg),
        .end_y_in        (in_ey_reg),
        .color           (in_color_reg),
        .active          (active_reg),
        .cur_x           (cur_x_reg),
        .cur_y           (cur_y_reg),
        .target_x        (target_x_reg),
        .target_y        (target_y_reg),
        .delta_x         (delta_x_reg),
        .delta_y         (delta_y_reg),
        .dir_x_neg       (dir_x_neg_reg),
        .dir_y_neg       (dir_y_neg_reg),
        .error_term      (error_term_reg),
        .line_color      (line_color_reg),
        .active_next     (active_next),
        .cur_x_next      (cur_x_next),
        .cur_y_next      (cur_y_next),
        .target_x_next   (target_x_next),
        .target_y_next   (target_y_next),
        .delta_x_next    (delta_x_next),
        .delta_y_next    (delta_y_next),
        .dir_x_neg_next  (dir_x_neg_next),
        .dir_y_neg_next  (dir_y_neg_next),
        .error_term_next (error_term_next),
        .line_color_next (line_color_next),
        .produce         (produce),
        .fin             (fin)
    );

    // A beat that yields no pixel never waits on the result register.
    assign advance  = in_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = MDataW'({out_color_reg, out_y_reg, out_x_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (s_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_mode_reg  <= s_tuser;
            in_sx_reg    <= s_tdata[COORD_BITS-1:0];
            in_sy_reg    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            in_ex_reg    <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            in_ey_reg    <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
            in_color_reg <= s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
        end
        if (advance)
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            dir_x_neg_reg  <= dir_x_neg_next;
            dir_y_neg_reg  <= dir_y_neg_next;
            error_term_reg <= error_term_next;
            line_color_reg <= line_color_next;
        end
        if (advance && produce)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_color_reg <= line_color_reg;
            out_last_reg  <= fin;
        end
    end

`ifndef SYNTHESIS
    a_step_yields_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produce |=> m_tvalid)
        else $error("step beat on an active line did not yield a pixel");

    a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_mode_reg == MODE_START) |=> active_reg)
        else $error("start beat did not activate a line");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produce && fin |=> !active_reg && m_tlast)
        else $error("final pixel did not end the line");

    a_walk_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && produce && !fin |=>
            (cur_x_reg != $past(cur_x_reg)) || (cur_y_reg != $past(cur_y_reg)))
        else $error("line walk failed to move");
`endif

endmodule

`default_nettype wire
